// ===== hw/rtl/utf8_decode_glyph_select_top_assert.svh =====
// Assertion macros for the UTF-8 decoder with glyph selection.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UTF8_DECODE_GLYPH_SELECT_TOP_ASSERT_SVH
`define UTF8_DECODE_GLYPH_SELECT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define U8_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define U8_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define U8_ASSERT_IMPLY(label, ante, cons)
`define U8_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== hw/rtl/utf8dg_pkg.sv =====
`default_nettype none
package utf8dg_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] EXT_LOW     = 21'h0000A0;
	localparam logic [CP_W-1:0] EXT_HIGH    = 21'h0000FF;
	localparam logic [CP_W-1:0] ASCII_END   = 21'h000080;
	localparam logic [6:0]      QUESTION    = 7'h3F;

	typedef struct packed {
		logic [1:0]      n_repl;
		logic            has_tail;
		logic [CP_W-1:0] tail_cp;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic       tbl;
		logic [6:0] idx;
	} glyph_t;

	function automatic glyph_t glyph_of(logic [CP_W-1:0] cp);
		glyph_t     g;
		logic [7:0] off;
		g.tbl = 1'b0;
		g.idx = QUESTION;
		off = cp[7:0] - EXT_LOW[7:0];
		if (cp < ASCII_END) begin
			g.idx = cp[6:0];
		end else if (cp >= EXT_LOW && cp <= EXT_HIGH) begin
			g.tbl = 1'b1;
			g.idx = off[6:0];
		end
		return g;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8_decode_glyph_select_top.sv =====
// A result word passes through the job queue and the output register after its byte is accepted.
// One byte is accepted per cycle while the queue is not full; its words then leave one by one.
// The job queue between decoder and word expander sets how long the input runs on during replays.
// Reset is asynchronous and active low; it clears the decode state, the queue and the output.
`default_nettype none
`include "utf8_decode_glyph_select_top_assert.svh"
module utf8_decode_glyph_select_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [20:0]      code_point,
	output logic             glyph_table,
	output logic [6:0]       glyph_index,
	output logic             last
);

	utf8dg_pkg::job_t    front_job;
	logic                front_job_valid;
	utf8dg_pkg::job_t    head_job;
	utf8dg_pkg::q_stat_t q_stat;
	logic                head_done;
	logic                accept;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	utf8dg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.job       (front_job),
		.job_valid (front_job_valid)
	);

	utf8dg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_job_valid),
		.wr_job (front_job),
		.rd_en  (head_done),
		.rd_job (head_job),
		.stat   (q_stat)
	);

	utf8dg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.head_valid  (!q_stat.empty),
		.head_done   (head_done),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.glyph_table (glyph_table),
		.glyph_index (glyph_index),
		.last        (last)
	);

	`U8_ASSERT_IMPLY(a_not_last_is_repl, !empty && !last, code_point == 21'h00FFFD)
	`U8_ASSERT_IMPLY(a_ext_range, !empty && glyph_table, code_point >= 21'hA0 && code_point <= 21'hFF)
	`U8_ASSERT_IMPLY(a_wide_is_question, !empty && code_point > 21'hFF, !glyph_table && glyph_index == 7'h3F)
	`U8_ASSERT_NEVER(a_done_without_head, head_done && q_stat.empty)

endmodule
`default_nettype wire

// ===== hw/rtl/utf8dg_front.sv =====
`default_nettype none
module utf8dg_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_byte,
	output utf8dg_pkg::job_t      job,
	output logic                  job_valid
);

	logic [1:0]                  need_q;
	logic [1:0]                  taken_q;
	logic [utf8dg_pkg::CP_W-1:0] pp_q;

	logic [1:0]                  need_d;
	logic [1:0]                  taken_d;
	logic [utf8dg_pkg::CP_W-1:0] pp_d;
	logic [1:0]                  taken_inc;
	logic [utf8dg_pkg::CP_W-1:0] pp_shift;
	logic                        is_cont;

	assign is_cont   = (in_byte[7:6] == 2'b10);
	assign taken_inc = taken_q + 2'd1;
	assign pp_shift  = {pp_q[utf8dg_pkg::CP_W-7:0], in_byte[5:0]};

	always_comb begin
		need_d       = need_q;
		taken_d      = taken_q;
		pp_d         = pp_q;
		job.n_repl   = 2'd0;
		job.has_tail = 1'b0;
		job.tail_cp  = utf8dg_pkg::REPLACEMENT;
		if (need_q != 2'd0 && is_cont) begin
			if (taken_inc == need_q) begin
				job.has_tail = 1'b1;
				job.tail_cp  = pp_shift;
				need_d       = 2'd0;
				taken_d      = 2'd0;
				pp_d         = '0;
			end else begin
				taken_d = taken_inc;
				pp_d    = pp_shift;
			end
		end else begin
			if (need_q != 2'd0) begin
				job.n_repl = taken_q + 2'd1;
			end
			need_d  = 2'd0;
			taken_d = 2'd0;
			pp_d    = '0;
			if (in_byte == 8'h00) begin
				job.has_tail = 1'b0;
			end else if (in_byte[7] == 1'b0) begin
				job.has_tail = 1'b1;
				job.tail_cp  = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				need_d = 2'd1;
				pp_d   = {16'd0, in_byte[4:0]};
			end else if (in_byte[7:4] == 4'b1110) begin
				need_d = 2'd2;
				pp_d   = {17'd0, in_byte[3:0]};
			end else if (in_byte[7:3] == 5'b11110) begin
				need_d = 2'd3;
				pp_d   = {18'd0, in_byte[2:0]};
			end else begin
				job.has_tail = 1'b1;
			end
		end
	end

	assign job_valid = accept && (job.n_repl != 2'd0 || job.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q  <= 2'd0;
			taken_q <= 2'd0;
			pp_q    <= '0;
		end else if (accept) begin
			need_q  <= need_d;
			taken_q <= taken_d;
			pp_q    <= pp_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8dg_queue.sv =====
`default_nettype none
module utf8dg_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire utf8dg_pkg::job_t  wr_job,
	input  wire logic              rd_en,
	output utf8dg_pkg::job_t       rd_job,
	output utf8dg_pkg::q_stat_t    stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	utf8dg_pkg::job_t mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_job     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8dg_back.sv =====
`default_nettype none
module utf8dg_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire utf8dg_pkg::job_t            head_job,
	input  wire logic                        head_valid,
	output logic                             head_done,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [utf8dg_pkg::CP_W-1:0]      code_point,
	output logic                             glyph_table,
	output logic [6:0]                       glyph_index,
	output logic                             last
);

	logic                        out_valid_q;
	logic [utf8dg_pkg::CP_W-1:0] cp_q;
	utf8dg_pkg::glyph_t          glyph_q;
	logic                        last_q;
	logic [1:0]                  sub_q;

	logic                        issue;
	logic                        is_repl;
	logic                        is_final;
	logic [utf8dg_pkg::CP_W-1:0] word_cp;

	assign issue    = head_valid && (!out_valid_q || pop);
	assign is_repl  = (sub_q < head_job.n_repl);
	assign is_final = ({1'b0, sub_q} + 3'd1) ==
		({1'b0, head_job.n_repl} + {2'd0, head_job.has_tail});
	assign word_cp  = is_repl ? utf8dg_pkg::REPLACEMENT : head_job.tail_cp;
	assign head_done = issue && is_final;

	always_ff @(posedge clk) begin
		if (issue) begin
			cp_q    <= word_cp;
			glyph_q <= utf8dg_pkg::glyph_of(word_cp);
			last_q  <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 2'd0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (issue) begin
				sub_q <= is_final ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign code_point  = cp_q;
	assign glyph_table = glyph_q.tbl;
	assign glyph_index = glyph_q.idx;
	assign last        = last_q;

endmodule
`default_nettype wire
